### rtl/vbt_pkg.sv
// Shared types and constants for the variometer beep tone controller.
// No dependencies; used by the divider, the top level and the checker.
package vbt_pkg;

    // Item field widths
    localparam int CLIMB_W = 12;
    localparam int TIME_W  = 32;
    localparam int TONE_W  = 11;
    localparam int MODE_W  = 2;
    localparam int GAP_W   = 10;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    // Configuration register widths and port
    localparam int LIFT_THR_W = 9;
    localparam int SINK_THR_W = 12;
    localparam int CONFIRM_W  = 4;
    localparam int BEEP_LEN_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SINK_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_CONF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SINK_CONF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SINK_TONE = 3'd5;

    // Audio modes
    localparam logic [MODE_W-1:0] MODE_SILENT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LIFT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SINK   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BAD    = 2'd3;

    // Run counters
    localparam int RUN_W = 4;
    localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

    // Map constants
    localparam int MAP_IN_HIGH  = 500;
    localparam int GAP_SLOW_MS  = 600;
    localparam int GAP_FAST_MS  = 80;
    localparam int TONE_LOW_HZ  = 800;
    localparam int TONE_HIGH_HZ = 1500;
    localparam int GAP_SPAN     = GAP_SLOW_MS - GAP_FAST_MS;
    localparam int TONE_SPAN    = TONE_HIGH_HZ - TONE_LOW_HZ;
    localparam int K_W          = 10;

    // Reset values of the configuration registers
    localparam int RST_LIFT_THR  = 30;
    localparam int RST_SINK_THR  = -200;
    localparam int RST_CONFIRM   = 5;
    localparam int RST_BEEP_LEN  = 80;
    localparam int RST_SINK_TONE = 300;

    // Divider: |d| * 700 stays below 2^21, |span| is at most 500
    localparam int NUM_W = 21;
    localparam int DEN_W = 9;
    localparam int CNT_W = 5;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### rtl/vbt_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on vbt_pkg for widths and the request/status structs.
module vbt_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  vbt_pkg::div_req_t         req,
    output vbt_pkg::div_stat_t        stat,
    output logic [vbt_pkg::NUM_W-1:0] quotient
);

    localparam int NUM_W = vbt_pkg::NUM_W;
    localparam int DEN_W = vbt_pkg::DEN_W;
    localparam int CNT_W = vbt_pkg::CNT_W;

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;
    logic             q_bit;
    logic [DEN_W-1:0] rem_next;

    always_comb begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        diff     = {1'b0, shifted} - {2'b00, den_reg};
        q_bit    = ~diff[DEN_W+1];
        // remainder stays below the divisor, so it fits the divisor width
        rem_next = q_bit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end else if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], q_bit};
        end else if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

### rtl/vario_beep_tone_controller.sv
// Accept to result: decide, then the beat update, if lift is not confirmed or the lift span is zero;
// if lift is confirmed: decide, two divider passes of 21 quotient steps, each ending in a done strobe,
// then the beat update. The beat update waits while an unaccepted result holds the output register.
// The input is not ready while an item is at work, so a new item waits until the last one is through.
// A finished result waits in the output register while the next item is accepted.
// Reset (synchronous, aresetn low): counters, tone state and time stamp clear, config
// registers return to their defaults, no result is pending.
module vario_beep_tone_controller (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata fields, low bit up: climb_cms[11:0], now_ms[43:12], zero pad [47:44]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [vbt_pkg::S_DATA_W-1:0]   s_tdata,
    // m_tdata fields, low bit up: buzzer_on[0], tone_hz[11:1], audio_mode[13:12], zero pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [vbt_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vbt_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CLIMB_W = vbt_pkg::CLIMB_W;
    localparam int TIME_W  = vbt_pkg::TIME_W;
    localparam int TONE_W  = vbt_pkg::TONE_W;
    localparam int MODE_W  = vbt_pkg::MODE_W;
    localparam int GAP_W   = vbt_pkg::GAP_W;
    localparam int RUN_W   = vbt_pkg::RUN_W;
    localparam int NUM_W   = vbt_pkg::NUM_W;
    localparam int DEN_W   = vbt_pkg::DEN_W;
    localparam int K_W     = vbt_pkg::K_W;
    localparam int D_W     = CLIMB_W + 1;
    localparam int QS_W    = NUM_W + 2;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DECIDE   = 3'd1;
    localparam logic [2:0] ST_DIV_GAP  = 3'd2;
    localparam logic [2:0] ST_DIV_TONE = 3'd3;
    localparam logic [2:0] ST_BEAT     = 3'd4;

    logic [2:0] state_reg, state_next;

    // configuration
    logic [vbt_pkg::LIFT_THR_W-1:0]        lift_thr_reg;
    logic signed [vbt_pkg::SINK_THR_W-1:0] sink_thr_reg;
    logic [vbt_pkg::CONFIRM_W-1:0]         lift_conf_reg;
    logic [vbt_pkg::CONFIRM_W-1:0]         sink_conf_reg;
    logic [vbt_pkg::BEEP_LEN_W-1:0]        beep_len_reg;
    logic [TONE_W-1:0]                     sink_tone_reg;

    // controller state
    logic [RUN_W-1:0]  lift_run_reg, sink_run_reg;
    logic              sounding_reg;
    logic [TIME_W-1:0] last_change_reg;
    logic [TONE_W-1:0] cur_tone_reg;

    // item in work
    logic signed [CLIMB_W-1:0] climb_reg;
    logic [TIME_W-1:0]         now_reg;
    logic [GAP_W-1:0]          gap_reg;
    logic [TONE_W-1:0]         hz_reg;

    logic                      out_valid_reg;
    logic [vbt_pkg::M_DATA_W-1:0] out_data_reg;

    vbt_pkg::div_req_t  div_req;
    vbt_pkg::div_stat_t div_stat;
    logic [NUM_W-1:0]   div_q;

    vbt_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // input decode
    logic signed [CLIMB_W-1:0] climb_in;
    logic signed [D_W-1:0]     climb_in_ext, thr_ext;
    logic                      in_lift, in_sink, accept;

    assign climb_in     = signed'(s_tdata[CLIMB_W-1:0]);
    assign climb_in_ext = D_W'(climb_in);
    assign thr_ext      = signed'({{(D_W - vbt_pkg::LIFT_THR_W){1'b0}}, lift_thr_reg});
    assign in_lift      = climb_in_ext > thr_ext;
    assign in_sink      = climb_in < sink_thr_reg;
    assign accept       = s_tvalid && s_tready;
    assign s_tready     = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;

    // map operands
    logic signed [D_W-1:0]   d_val;
    logic [CLIMB_W-1:0]      d_mag;
    logic signed [DEN_W:0]   span;
    logic [DEN_W-1:0]        span_mag;
    logic                    q_neg;
    logic [K_W-1:0]          mul_k;
    logic [CLIMB_W+K_W-1:0]  prod;
    logic signed [QS_W-1:0]  q_signed, gap_raw, tone_raw;
    logic [GAP_W-1:0]        gap_clamped;
    logic [TONE_W-1:0]       tone_clamped;
    logic                    lift_ok, sink_ok;

    always_comb begin
        d_val    = D_W'(climb_reg) - thr_ext;
        d_mag    = d_val[D_W-1] ? CLIMB_W'(-d_val) : CLIMB_W'(d_val);
        span     = (DEN_W+1)'(vbt_pkg::MAP_IN_HIGH) - signed'({1'b0, lift_thr_reg});
        span_mag = span[DEN_W] ? DEN_W'(-span) : DEN_W'(span);
        q_neg    = d_val[D_W-1] ^ span[DEN_W];
        mul_k    = (state_reg == ST_DECIDE) ? K_W'(vbt_pkg::GAP_SPAN) : K_W'(vbt_pkg::TONE_SPAN);
        prod     = d_mag * mul_k;

        q_signed = q_neg ? -signed'(QS_W'(div_q)) : signed'(QS_W'(div_q));
        gap_raw  = QS_W'(vbt_pkg::GAP_SLOW_MS) - q_signed;
        tone_raw = QS_W'(vbt_pkg::TONE_LOW_HZ) + q_signed;

        if (gap_raw < QS_W'(vbt_pkg::GAP_FAST_MS)) begin
            gap_clamped = GAP_W'(vbt_pkg::GAP_FAST_MS);
        end else if (gap_raw > QS_W'(vbt_pkg::GAP_SLOW_MS)) begin
            gap_clamped = GAP_W'(vbt_pkg::GAP_SLOW_MS);
        end else begin
            gap_clamped = gap_raw[GAP_W-1:0];
        end

        if (tone_raw < QS_W'(vbt_pkg::TONE_LOW_HZ)) begin
            tone_clamped = TONE_W'(vbt_pkg::TONE_LOW_HZ);
        end else if (tone_raw > QS_W'(vbt_pkg::TONE_HIGH_HZ)) begin
            tone_clamped = TONE_W'(vbt_pkg::TONE_HIGH_HZ);
        end else begin
            tone_clamped = tone_raw[TONE_W-1:0];
        end

        lift_ok = lift_run_reg >= lift_conf_reg;
        sink_ok = sink_run_reg >= sink_conf_reg;
    end

    logic beat_fire;
    assign beat_fire = (state_reg == ST_BEAT) && (!out_valid_reg || m_tready);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        div_req.start = 1'b0;
        div_req.num   = prod[NUM_W-1:0];
        div_req.den   = span_mag;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (lift_ok && span != '0) begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_GAP;
                end else begin
                    state_next = ST_BEAT;
                end
            end
            ST_DIV_GAP: begin
                if (div_stat.done) begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_TONE;
                end
            end
            ST_DIV_TONE: begin
                if (div_stat.done) state_next = ST_BEAT;
            end
            ST_BEAT: begin
                if (beat_fire) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // beat rules
    logic [TIME_W-1:0] elapsed;
    logic              sounding_next;
    logic [TIME_W-1:0] last_change_next;
    logic [TONE_W-1:0] cur_tone_next;
    logic [MODE_W-1:0] mode;

    always_comb begin
        elapsed          = now_reg - last_change_reg;
        sounding_next    = sounding_reg;
        last_change_next = last_change_reg;
        cur_tone_next    = cur_tone_reg;
        if (lift_ok) begin
            mode = vbt_pkg::MODE_LIFT;
            if (!sounding_reg && elapsed > TIME_W'(gap_reg)) begin
                cur_tone_next    = hz_reg;
                sounding_next    = 1'b1;
                last_change_next = now_reg;
            end else if (sounding_reg && elapsed > TIME_W'(beep_len_reg)) begin
                sounding_next    = 1'b0;
                last_change_next = now_reg;
            end
        end else if (sink_ok) begin
            mode = vbt_pkg::MODE_SINK;
            if (!sounding_reg) begin
                cur_tone_next = sink_tone_reg;
                sounding_next = 1'b1;
            end
        end else begin
            mode          = vbt_pkg::MODE_SILENT;
            sounding_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            lift_run_reg    <= '0;
            sink_run_reg    <= '0;
            sounding_reg    <= 1'b0;
            last_change_reg <= '0;
            cur_tone_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                if (in_lift) begin
                    if (lift_run_reg < vbt_pkg::RUN_MAX) lift_run_reg <= lift_run_reg + 1'b1;
                    sink_run_reg <= '0;
                end else if (in_sink) begin
                    if (sink_run_reg < vbt_pkg::RUN_MAX) sink_run_reg <= sink_run_reg + 1'b1;
                    lift_run_reg <= '0;
                end else begin
                    lift_run_reg <= '0;
                    sink_run_reg <= '0;
                end
            end
            if (beat_fire) begin
                out_valid_reg   <= 1'b1;
                sounding_reg    <= sounding_next;
                last_change_reg <= last_change_next;
                cur_tone_reg    <= cur_tone_next;
            end else if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            climb_reg <= climb_in;
            now_reg   <= s_tdata[CLIMB_W +: TIME_W];
        end
        if (state_reg == ST_DECIDE) begin
            // zero span takes the map's end values
            gap_reg <= GAP_W'(vbt_pkg::GAP_FAST_MS);
            hz_reg  <= TONE_W'(vbt_pkg::TONE_HIGH_HZ);
        end
        if (state_reg == ST_DIV_GAP && div_stat.done) gap_reg <= gap_clamped;
        if (state_reg == ST_DIV_TONE && div_stat.done) hz_reg <= tone_clamped;
        if (beat_fire) begin
            out_data_reg <= {2'b00, mode, cur_tone_next, sounding_next};
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lift_thr_reg  <= vbt_pkg::LIFT_THR_W'(vbt_pkg::RST_LIFT_THR);
            sink_thr_reg  <= vbt_pkg::SINK_THR_W'(vbt_pkg::RST_SINK_THR);
            lift_conf_reg <= vbt_pkg::CONFIRM_W'(vbt_pkg::RST_CONFIRM);
            sink_conf_reg <= vbt_pkg::CONFIRM_W'(vbt_pkg::RST_CONFIRM);
            beep_len_reg  <= vbt_pkg::BEEP_LEN_W'(vbt_pkg::RST_BEEP_LEN);
            sink_tone_reg <= TONE_W'(vbt_pkg::RST_SINK_TONE);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                vbt_pkg::REG_LIFT_THR:  lift_thr_reg  <= cfg_data[vbt_pkg::LIFT_THR_W-1:0];
                vbt_pkg::REG_SINK_THR:  sink_thr_reg  <= signed'(cfg_data);
                vbt_pkg::REG_LIFT_CONF: lift_conf_reg <= cfg_data[vbt_pkg::CONFIRM_W-1:0];
                vbt_pkg::REG_SINK_CONF: sink_conf_reg <= cfg_data[vbt_pkg::CONFIRM_W-1:0];
                vbt_pkg::REG_BEEP_LEN:  beep_len_reg  <= cfg_data[vbt_pkg::BEEP_LEN_W-1:0];
                vbt_pkg::REG_SINK_TONE: sink_tone_reg <= cfg_data[TONE_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### rtl/vbt_checker.sv
// Port-level checks for the variometer beep tone controller, bound to the top level.
// Depends on vbt_pkg for widths and mode codes.
module vbt_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [vbt_pkg::M_DATA_W-1:0]   m_tdata
);

    logic [vbt_pkg::MODE_W-1:0] out_mode;
    assign out_mode = m_tdata[13:12];

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an accepted item keeps the input closed for at least the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

    a_mode_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_mode != vbt_pkg::MODE_BAD)
        else $error("undefined audio mode");

    // silence always turns the buzzer off
    a_silent_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_mode == vbt_pkg::MODE_SILENT |-> !m_tdata[0])
        else $error("buzzer on in silent mode");

endmodule

bind vario_beep_tone_controller vbt_checker u_vbt_checker (.*);
